/* rtl/sliding_median_threshold_alert_defines.svh */
// assertion macros shared by the sliding median threshold alert rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef SLIDING_MEDIAN_THRESHOLD_ALERT_DEFINES_SVH
`define SLIDING_MEDIAN_THRESHOLD_ALERT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SMTA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smta: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SMTA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smta: next-cycle check failed");

`endif

/* rtl/smta_pkg.sv */
// shared constants and controller/datapath interface types for the median alert block
// no dependencies
`default_nettype none

package smta_pkg;

    // value range and window depth
    localparam int VALUE_BINS = 256;
    localparam int WINDOW_MAX = 256;

    // field and storage widths
    localparam int SAMPLE_W = 8;
    localparam int BIN_W    = $clog2(VALUE_BINS);
    localparam int POS_W    = $clog2(WINDOW_MAX);
    localparam int LEN_W    = 9;
    localparam int CNT_W    = 9;
    localparam int ACC_W    = CNT_W + 1;
    localparam int TM_W     = 9;
    localparam int TOTAL_W  = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic       REG_WINDOW_LEN   = 1'b0;
    localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 9'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cap;       // capture the accepted transaction
        logic walk_rd;   // read the next histogram bin of the median walk
        logic ring_rd;   // read the oldest sample from the ring
        logic old_rd;    // read the histogram bin of the oldest sample
        logic old_wr;    // write back that bin decremented
        logic new_rd;    // read the histogram bin of the new sample
        logic new_wr;    // write back incremented, store sample, commit result
        logic out_load;  // hand the result to the output register
    } smta_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic warm;      // window not yet full
        logic bin_last;  // walk is at the last bin
    } smta_sts_t;

endpackage

`default_nettype wire

/* rtl/smta_ctrl.sv */
// sequencing state machine of the median alert block
// depends on smta_pkg and the assertion macro header
`default_nettype none
`include "sliding_median_threshold_alert_defines.svh"

module smta_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              out_free,
    input  wire smta_pkg::smta_sts_t sts,
    output smta_pkg::smta_cmd_t    cmd
);
    import smta_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_END,
        ST_OLD_RD,
        ST_OLD_WR,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.cap = accept;
                if (accept) begin
                    state_next = sts.warm ? ST_NEW_RD : ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_rd = 1'b1;
                if (sts.bin_last) begin
                    state_next = ST_WALK_END;
                end
            end
            ST_WALK_END: begin
                // last bin accumulates while the oldest sample is fetched
                cmd.ring_rd = 1'b1;
                state_next  = ST_OLD_RD;
            end
            ST_OLD_RD: begin
                cmd.old_rd = 1'b1;
                state_next = ST_OLD_WR;
            end
            ST_OLD_WR: begin
                cmd.old_wr = 1'b1;
                state_next = ST_NEW_RD;
            end
            ST_NEW_RD: begin
                cmd.new_rd = 1'b1;
                state_next = ST_NEW_WR;
            end
            ST_NEW_WR: begin
                cmd.new_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SMTA_ASSERT_NXT(a_warm_skips_walk, aclk, aresetn, accept && sts.warm, state_reg == ST_NEW_RD)
    `SMTA_ASSERT_NXT(a_full_walks, aclk, aresetn, accept && !sts.warm, state_reg == ST_WALK)
    `SMTA_ASSERT_NXT(a_result_held, aclk, aresetn, (state_reg == ST_DONE) && !out_free, state_reg == ST_DONE)

endmodule

`default_nettype wire

/* rtl/smta_datapath.sv */
// histogram, sample ring, median walk and alert counter of the median alert block
// depends on smta_pkg and the assertion macro header
`default_nettype none
`include "sliding_median_threshold_alert_defines.svh"

module smta_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           restart,
    input  wire logic [smta_pkg::LEN_W-1:0]     len,
    input  wire logic [smta_pkg::SAMPLE_W-1:0]  sample,
    input  wire smta_pkg::smta_cmd_t            cmd,
    output smta_pkg::smta_sts_t                 sts,
    output logic                                res_alert,
    output logic                                res_warming,
    output logic [smta_pkg::TM_W-1:0]           res_threshold,
    output logic [smta_pkg::TOTAL_W-1:0]        res_alert_total
);
    import smta_pkg::*;

    // storage
    logic [CNT_W-1:0]    hist_mem [VALUE_BINS];
    logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
    logic [VALUE_BINS-1:0] hvalid_reg;

    // transaction context
    logic [SAMPLE_W-1:0] sample_reg;
    logic                warm_reg;
    logic [POS_W-1:0]    pos_cur_reg;
    logic [LEN_W-1:0]    rank_a_reg;
    logic [LEN_W-1:0]    rank_b_reg;

    // window bookkeeping
    logic [POS_W-1:0]    pos_reg;
    logic [LEN_W-1:0]    fill_reg;
    logic [TOTAL_W-1:0]  total_reg;

    // median walk
    logic [BIN_W-1:0]    bin_reg;
    logic                walk_q_reg;
    logic [BIN_W-1:0]    tag_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                found_a_reg;
    logic                found_b_reg;
    logic [BIN_W-1:0]    val_a_reg;
    logic [BIN_W-1:0]    val_b_reg;

    // memory read data
    logic [CNT_W-1:0]    hist_q_reg;
    logic                hvld_q_reg;
    logic [SAMPLE_W-1:0] ring_q_reg;

    // combinational
    logic [POS_W-1:0]    pos_eff;
    logic [LEN_W-1:0]    half;
    logic [LEN_W-1:0]    rank_a;
    logic [CNT_W-1:0]    hist_cnt;
    logic [ACC_W-1:0]    acc_next;
    logic [BIN_W-1:0]    hist_addr;
    logic                hist_we;
    logic [CNT_W-1:0]    hist_wdata;
    logic [LEN_W-1:0]    pos_inc;
    logic [TM_W-1:0]     tm;
    logic                alert_now;
    logic [TOTAL_W-1:0]  total_next;

    // ring position wraps if the window shrank
    assign pos_eff = ({1'b0, pos_reg} >= len) ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos_cur_reg} + LEN_W'(1);

    // rank of the lower middle value; odd windows use the upper one twice
    assign half   = {1'b0, len[LEN_W-1:1]};
    assign rank_a = len[0] ? (half + LEN_W'(1)) : half;

    assign sts.warm     = (fill_reg < len);
    assign sts.bin_last = (bin_reg == BIN_W'(VALUE_BINS - 1));

    // bins never written since restart read as empty
    assign hist_cnt = hvld_q_reg ? hist_q_reg : '0;
    assign acc_next = acc_reg + {1'b0, hist_cnt};

    // histogram address and write data
    always_comb begin
        if (cmd.walk_rd) begin
            hist_addr = bin_reg;
        end else if (cmd.old_rd || cmd.old_wr) begin
            hist_addr = ring_q_reg;
        end else if (cmd.new_rd || cmd.new_wr) begin
            hist_addr = sample_reg;
        end else begin
            hist_addr = bin_reg;
        end
        hist_we = cmd.old_wr || cmd.new_wr;
        if (cmd.old_wr) begin
            hist_wdata = (hist_cnt == '0) ? '0 : (hist_cnt - CNT_W'(1));
        end else begin
            hist_wdata = hist_cnt + CNT_W'(1);
        end
    end

    // threshold, alert decision and saturating total
    assign tm         = {1'b0, val_a_reg} + {1'b0, val_b_reg};
    assign alert_now  = !warm_reg && ({1'b0, sample_reg} >= tm);
    assign total_next = (alert_now && (total_reg != '1)) ? (total_reg + TOTAL_W'(1)) : total_reg;

    // histogram memory
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_addr] <= hist_wdata;
        end
        hist_q_reg <= hist_mem[hist_addr];
        hvld_q_reg <= hvalid_reg[hist_addr];
    end

    // per-bin valid flags, cleared at reset and on restart
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            hvalid_reg <= '0;
        end else if (hist_we) begin
            hvalid_reg[hist_addr] <= 1'b1;
        end
    end

    // sample ring
    always_ff @(posedge aclk) begin
        if (cmd.new_wr) begin
            ring_mem[pos_cur_reg] <= sample_reg;
        end
        if (cmd.ring_rd) begin
            ring_q_reg <= ring_mem[pos_cur_reg];
        end
    end

    // transaction context and walk payload
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            sample_reg  <= sample;
            warm_reg    <= sts.warm;
            pos_cur_reg <= pos_eff;
            rank_a_reg  <= rank_a;
            rank_b_reg  <= half + LEN_W'(1);
            acc_reg     <= '0;
            val_a_reg   <= '0;
            val_b_reg   <= '0;
        end else if (walk_q_reg) begin
            acc_reg <= acc_next;
            if (!found_a_reg && ({1'b0, rank_a_reg} <= acc_next)) begin
                val_a_reg <= tag_reg;
            end
            if (!found_b_reg && ({1'b0, rank_b_reg} <= acc_next)) begin
                val_b_reg <= tag_reg;
            end
        end
        tag_reg <= bin_reg;
    end

    // walk control and window bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg     <= '0;
            walk_q_reg  <= 1'b0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
        end else begin
            walk_q_reg <= cmd.walk_rd;
            if (cmd.cap) begin
                bin_reg     <= '0;
                found_a_reg <= 1'b0;
                found_b_reg <= 1'b0;
            end else begin
                if (cmd.walk_rd) begin
                    bin_reg <= bin_reg + BIN_W'(1);
                end
                if (walk_q_reg && ({1'b0, rank_a_reg} <= acc_next)) begin
                    found_a_reg <= 1'b1;
                end
                if (walk_q_reg && ({1'b0, rank_b_reg} <= acc_next)) begin
                    found_b_reg <= 1'b1;
                end
            end
            if (restart) begin
                pos_reg  <= '0;
                fill_reg <= '0;
            end else if (cmd.new_wr) begin
                pos_reg <= (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
                if (warm_reg) begin
                    fill_reg <= fill_reg + LEN_W'(1);
                end
            end
            if (cmd.new_wr) begin
                total_reg <= total_next;
            end
        end
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.new_wr) begin
            res_alert       <= alert_now;
            res_warming     <= warm_reg;
            res_threshold   <= warm_reg ? '0 : tm;
            res_alert_total <= total_next;
        end
    end

    `SMTA_ASSERT_IMP(a_fill_in_window, aclk, aresetn, 1'b1, fill_reg <= len)
    `SMTA_ASSERT_IMP(a_upper_rank_after_lower, aclk, aresetn, found_b_reg, found_a_reg)
    `SMTA_ASSERT_NXT(a_walk_read_tracked, aclk, aresetn, cmd.walk_rd, walk_q_reg)

endmodule

`default_nettype wire

/* rtl/sliding_median_threshold_alert.sv */
// Sliding-window median threshold alert. Each input transaction carries one 8-bit sample;
// each produces exactly one result transaction. The block keeps the last window_len
// samples (1..256, 0 taken as 1, larger values as 256) in a ring and a 256-bin value
// histogram. While the window fills, results are flagged warming with alert and
// threshold zero. After that, twice the median is found by a cumulative walk that
// reads one histogram bin per cycle through the single histogram memory port, and
// alert is raised when the sample is at least that value; alert_total saturates.
// A full-window transaction runs the bin walk, then accumulates the last bin while the oldest
// sample is fetched, then the remove and insert read-modify-writes of the histogram and the
// hand-over to the output register; a warming transaction skips the walk and the removal.
// One transaction is in work at a time, and the next is accepted while a finished result
// still waits in the output register.
// Writing window_len (APB, byte address 0) restarts the window at once; the alert
// total is kept. No clearing pass is needed after reset.
// depends on smta_pkg, smta_ctrl and smta_datapath
`default_nettype none

module sliding_median_threshold_alert (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [smta_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [smta_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [smta_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [smta_pkg::SAMPLE_W-1:0]     s_sample,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_alert,
    output logic                                   m_warming,
    output logic [smta_pkg::TM_W-1:0]              m_threshold,
    output logic [smta_pkg::TOTAL_W-1:0]           m_alert_total
);
    import smta_pkg::*;

    logic [LEN_W-1:0]   window_len_reg;
    logic [LEN_W-1:0]   len_eff;
    logic               cfg_wr;
    logic               out_free;
    smta_cmd_t          cmd;
    smta_sts_t          sts;
    logic               res_alert;
    logic               res_warming;
    logic [TM_W-1:0]    res_threshold;
    logic [TOTAL_W-1:0] res_alert_total;
    logic               m_valid_reg;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ?
                    {{(APB_DATA_W-LEN_W){1'b0}}, window_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
        end else if (cfg_wr) begin
            window_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // effective window length
    always_comb begin
        if (window_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (window_len_reg > LEN_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = window_len_reg;
        end
    end

    smta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    smta_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .restart         (cfg_wr),
        .len             (len_eff),
        .sample          (s_sample),
        .cmd             (cmd),
        .sts             (sts),
        .res_alert       (res_alert),
        .res_warming     (res_warming),
        .res_threshold   (res_threshold),
        .res_alert_total (res_alert_total)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_alert       <= res_alert;
            m_warming     <= res_warming;
            m_threshold   <= res_threshold;
            m_alert_total <= res_alert_total;
        end
    end

endmodule

`default_nettype wire
